### rtl/ssbi_pkg.sv
// ----------------------------------------------------------------------------
// ssbi_pkg
// shared types and constants of the split-sum brdf integrator
// ----------------------------------------------------------------------------
package ssbi_pkg;

    localparam int unsigned IN_TDATA_W  = 72;
    localparam int unsigned OUT_TDATA_W = 32;

    // iterative divider geometry
    localparam int unsigned DIV_NUM_W = 64;
    localparam int unsigned DIV_DEN_W = 46;
    localparam int unsigned DIV_Q_W   = 33;
    localparam int unsigned DIV_CNT_W = 6;

    // iterative square root geometry
    localparam int unsigned SQ_RAD_W  = 30;
    localparam int unsigned SQ_ROOT_W = 15;
    localparam int unsigned SQ_CNT_W  = 4;

    localparam int unsigned MUL_W  = 35;
    localparam int unsigned PROD_W = 70;

    localparam logic [15:0] Q15_ONE = 16'd32768;
    localparam logic [29:0] SUM_MAX = 30'h3FFF_FFFF;
    localparam logic [19:0] W_MAX   = 20'hF_FFFF;

    typedef struct packed {
        logic done;
        logic ovf;
    } div_stat_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_VSQ,
        ST_ROOT_GO,
        ST_ROOT,
        ST_HX,
        ST_HZ,
        ST_VD,
        ST_NDL,
        ST_CHK,
        ST_KSET,
        ST_D1M,
        ST_D1GO,
        ST_DIV1,
        ST_D2M,
        ST_D2GO,
        ST_DIV2,
        ST_GM,
        ST_GSET,
        ST_HVM,
        ST_WM,
        ST_WGO,
        ST_DIV3,
        ST_F4M,
        ST_F5M,
        ST_F5,
        ST_SC,
        ST_BI,
        ST_BADD,
        ST_DONE
    } state_t;

endpackage

### rtl/ssbi_mul.sv
// ----------------------------------------------------------------------------
// ssbi_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
module ssbi_mul (
    input  logic                                 aclk,
    input  logic signed [ssbi_pkg::MUL_W-1:0]    mul_a,
    input  logic signed [ssbi_pkg::MUL_W-1:0]    mul_b,
    output logic signed [ssbi_pkg::PROD_W-1:0]   prod
);
    import ssbi_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    assign prod = prod_reg;

endmodule

### rtl/ssbi_div.sv
// ----------------------------------------------------------------------------
// ssbi_div
// restoring divider, one quotient bit per cycle, overflow flag
// ----------------------------------------------------------------------------
module ssbi_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [ssbi_pkg::DIV_NUM_W-1:0]      num,
    input  logic [ssbi_pkg::DIV_DEN_W-1:0]      den,
    output logic [ssbi_pkg::DIV_Q_W-1:0]        quot,
    output ssbi_pkg::div_stat_t                 stat
);
    import ssbi_pkg::*;

    logic [DIV_DEN_W:0]   rem_reg, rem_next;
    logic [DIV_Q_W-1:0]   sh_reg, sh_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic                 ovf_reg, ovf_next;
    logic [DIV_DEN_W:0]   rem_s;
    logic [DIV_DEN_W:0]   init_rem;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        den_reg <= den_next;
        ovf_reg <= ovf_next;
    end

    always_comb begin
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        ovf_next  = ovf_reg;
        done_next = 1'b0;
        init_rem  = (DIV_DEN_W+1)'(num[DIV_NUM_W-1:DIV_Q_W]);
        rem_s     = {rem_reg[DIV_DEN_W-1:0], sh_reg[DIV_Q_W-1]};
        if (start && !busy_reg) begin
            rem_next  = init_rem;
            sh_next   = num[DIV_Q_W-1:0];
            den_next  = den;
            ovf_next  = (init_rem >= {1'b0, den});
            cnt_next  = DIV_CNT_W'(DIV_Q_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_s >= {1'b0, den_reg}) begin
                rem_next = rem_s - {1'b0, den_reg};
                sh_next  = {sh_reg[DIV_Q_W-2:0], 1'b1};
            end else begin
                rem_next = rem_s;
                sh_next  = {sh_reg[DIV_Q_W-2:0], 1'b0};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    assign quot      = sh_reg;
    assign stat.done = done_reg;
    assign stat.ovf  = ovf_reg;

endmodule

### rtl/ssbi_sqrt.sv
// ----------------------------------------------------------------------------
// ssbi_sqrt
// digit-by-digit floor square root, one root bit per cycle
// ----------------------------------------------------------------------------
module ssbi_sqrt (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic [ssbi_pkg::SQ_RAD_W-1:0]      rad,
    output logic [ssbi_pkg::SQ_ROOT_W-1:0]     root,
    output logic                               done
);
    import ssbi_pkg::*;

    localparam int unsigned REM_W = SQ_ROOT_W + 3;

    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [SQ_ROOT_W-1:0] root_reg, root_next;
    logic [SQ_RAD_W-1:0]  rad_reg, rad_next;
    logic [SQ_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [REM_W-1:0]     rem_s, trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        root_reg <= root_next;
        rad_reg  <= rad_next;
    end

    always_comb begin
        rem_next  = rem_reg;
        root_next = root_reg;
        rad_next  = rad_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_s     = {rem_reg[REM_W-3:0], rad_reg[SQ_RAD_W-1:SQ_RAD_W-2]};
        trial     = {1'b0, root_reg, 2'b01};
        if (start && !busy_reg) begin
            rem_next  = '0;
            root_next = '0;
            rad_next  = rad;
            cnt_next  = SQ_CNT_W'(SQ_ROOT_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rad_next = {rad_reg[SQ_RAD_W-3:0], 2'b00};
            if (rem_s >= trial) begin
                rem_next  = rem_s - trial;
                root_next = {root_reg[SQ_ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_s;
                root_next = {root_reg[SQ_ROOT_W-2:0], 1'b0};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

### rtl/split_sum_brdf_integrator.sv
// ----------------------------------------------------------------------------
// split_sum_brdf_integrator
// ggx split-sum environment brdf integration, one sample per input word
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one half-vector sample per word, view cosine and roughness
//   repeated through a run; s_tlast marks the last sample of the run
//   m_ channel: one word per run with the scale and bias averages
//   the block works on one sample at a time: s_tready stays low from accept
//   until the sample is done; a counted sample uses one 15-step square root,
//   three 33-step divisions on the shared divider and 15 passes through the
//   shared multiplier; with zero k and a light term that rounds to zero the
//   second division is skipped
//   a sample that fails the geometry test (light below the horizon, or vdoth
//   or hz not positive) adds nothing to the sums
//   m_tvalid rises once the last sample is done, later while the previous
//   result is still unread
//   the result sits in an output register; new samples are taken while it
//   waits, only the next last sample waits until the old result is taken
//   reset clears the sums, the sequencer and the output valid
// ----------------------------------------------------------------------------
module split_sum_brdf_integrator #(
    parameter int unsigned LOG2_SAMPLES = 10
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // view_cosine[15:0], surface_roughness[31:16], half_x[48:32],
    // half_z[64:49], zero pad above
    input  logic [ssbi_pkg::IN_TDATA_W-1:0]       s_tdata,
    input  logic                                  s_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // scale_a[15:0], bias_b[31:16]
    output logic [ssbi_pkg::OUT_TDATA_W-1:0]      m_tdata
);
    import ssbi_pkg::*;

    // registers
    state_t             state_reg, state_next;
    logic [15:0]        v_reg, v_next;
    logic [15:0]        r_reg, r_next;
    logic signed [16:0] hx_reg, hx_next;
    logic [15:0]        hz_reg, hz_next;
    logic               last_reg, last_next;
    logic [14:0]        vx_reg, vx_next;
    logic signed [32:0] t_reg, t_next;
    logic signed [32:0] vdoth_reg, vdoth_next;
    logic [17:0]        nl_reg, nl_next;
    logic [29:0]        k_reg, k_next;
    logic [32:0]        g1v_reg, g1v_next;
    logic [32:0]        g1n_reg, g1n_next;
    logic [33:0]        g_reg, g_next;
    logic [45:0]        den_reg, den_next;
    logic [19:0]        w_reg, w_next;
    logic [15:0]        fc_reg, fc_next;
    logic [15:0]        f5_reg, f5_next;
    logic [29:0]        scale_sum_reg, scale_sum_next;
    logic [29:0]        bias_sum_reg, bias_sum_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [31:0]        m_tdata_reg, m_tdata_next;

    // shared units
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic                     div_start;
    logic [DIV_NUM_W-1:0]     div_num;
    logic [DIV_DEN_W-1:0]     div_den;
    logic [DIV_Q_W-1:0]       div_q;
    div_stat_t                div_st;
    logic                     sq_start;
    logic [SQ_RAD_W-1:0]      sq_rad;
    logic [SQ_ROOT_W-1:0]     sq_root;
    logic                     sq_done;

    // helpers
    logic signed [49:0] ndotl_c;
    logic signed [49:0] nl_tmp;
    logic [33:0]        vd_tmp;
    logic [18:0]        vd15;
    logic [34:0]        dsum;
    logic [30:0]        one_minus_k;
    logic [21:0]        rq;
    logic [30:0]        add_s;
    logic [30:0]        add_b;
    logic [30:0]        avg_s, avg_b;
    logic [30:0]        half_lsb;
    logic [15:0]        in_v, in_r, in_hz;
    logic signed [16:0] in_hx;
    logic               out_free;

    ssbi_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    ssbi_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .quot    (div_q),
        .stat    (div_st)
    );

    ssbi_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .rad     (sq_rad),
        .root    (sq_root),
        .done    (sq_done)
    );

    function automatic logic signed [MUL_W-1:0] uext(input logic [MUL_W-2:0] x);
        return $signed({1'b0, x});
    endfunction

    // round a q15 product half up
    function automatic logic [21:0] rnd_q15(input logic signed [PROD_W-1:0] x);
        logic [37:0] t;
        t = x[37:0] + 38'd16384;
        return t[36:15];
    endfunction

    function automatic logic [15:0] avg_sat(input logic [30:0] x);
        return (x > 31'd65535) ? 16'hFFFF : x[15:0];
    endfunction

    // input clamping
    always_comb begin
        in_v = s_tdata[15:0];
        if (in_v == 16'd0) in_v = 16'd1;
        if (in_v > Q15_ONE) in_v = Q15_ONE;
        in_r = s_tdata[31:16];
        if (in_r > Q15_ONE) in_r = Q15_ONE;
        in_hz = s_tdata[64:49];
        if (in_hz > Q15_ONE) in_hz = Q15_ONE;
        in_hx = $signed(s_tdata[48:32]);
        if (in_hx[16]) begin
            if (in_hx < -17'sd32768) in_hx = -17'sd32768;
        end else begin
            if (in_hx > 17'sd32768) in_hx = 17'sd32768;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            scale_sum_reg <= '0;
            bias_sum_reg  <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            scale_sum_reg <= scale_sum_next;
            bias_sum_reg  <= bias_sum_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        v_reg       <= v_next;
        r_reg       <= r_next;
        hx_reg      <= hx_next;
        hz_reg      <= hz_next;
        last_reg    <= last_next;
        vx_reg      <= vx_next;
        t_reg       <= t_next;
        vdoth_reg   <= vdoth_next;
        nl_reg      <= nl_next;
        k_reg       <= k_next;
        g1v_reg     <= g1v_next;
        g1n_reg     <= g1n_next;
        g_reg       <= g_next;
        den_reg     <= den_next;
        w_reg       <= w_next;
        fc_reg      <= fc_next;
        f5_reg      <= f5_next;
        m_tdata_reg <= m_tdata_next;
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        v_next         = v_reg;
        r_next         = r_reg;
        hx_next        = hx_reg;
        hz_next        = hz_reg;
        last_next      = last_reg;
        vx_next        = vx_reg;
        t_next         = t_reg;
        vdoth_next     = vdoth_reg;
        nl_next        = nl_reg;
        k_next         = k_reg;
        g1v_next       = g1v_reg;
        g1n_next       = g1n_reg;
        g_next         = g_reg;
        den_next       = den_reg;
        w_next         = w_reg;
        fc_next        = fc_reg;
        f5_next        = f5_reg;
        scale_sum_next = scale_sum_reg;
        bias_sum_next  = bias_sum_reg;
        m_tdata_next   = m_tdata_reg;
        out_free       = !m_tvalid_reg || m_tready;
        m_tvalid_next  = m_tvalid_reg && !m_tready;

        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        sq_start  = 1'b0;
        sq_rad    = 30'(31'h4000_0000 - {1'b0, prod[29:0]});

        ndotl_c     = $signed({prod[48:0], 1'b0}) - $signed({4'b0, v_reg, 30'b0});
        nl_tmp      = ndotl_c + 50'sd536870912;
        vd_tmp      = {1'b0, vdoth_reg} + 34'd16384;
        vd15        = vd_tmp[33:15];
        one_minus_k = 31'h4000_0000 - {1'b0, k_reg};
        dsum        = prod[48:15] + {5'b0, k_reg};
        rq          = rnd_q15(prod);
        add_s       = {1'b0, scale_sum_reg} + {9'b0, rq};
        add_b       = {1'b0, bias_sum_reg} + {9'b0, rq};
        half_lsb    = 31'd1 << (LOG2_SAMPLES - 1);
        avg_s       = ({1'b0, scale_sum_reg} + half_lsb) >> LOG2_SAMPLES;
        avg_b       = ({1'b0, bias_sum_reg} + half_lsb) >> LOG2_SAMPLES;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    v_next     = in_v;
                    r_next     = in_r;
                    hx_next    = in_hx;
                    hz_next    = in_hz;
                    last_next  = s_tlast;
                    state_next = ST_VSQ;
                end
            end
            ST_VSQ: begin
                mul_a      = uext(34'(v_reg));
                mul_b      = uext(34'(v_reg));
                state_next = ST_ROOT_GO;
            end
            ST_ROOT_GO: begin
                sq_start   = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                if (sq_done) begin
                    vx_next    = sq_root;
                    state_next = ST_HX;
                end
            end
            ST_HX: begin
                mul_a      = uext(34'(vx_reg));
                mul_b      = MUL_W'(hx_reg);
                state_next = ST_HZ;
            end
            ST_HZ: begin
                t_next     = prod[32:0];
                mul_a      = uext(34'(v_reg));
                mul_b      = uext(34'(hz_reg));
                state_next = ST_VD;
            end
            ST_VD: begin
                vdoth_next = t_reg + $signed(prod[32:0]);
                state_next = ST_NDL;
            end
            ST_NDL: begin
                mul_a      = MUL_W'(vdoth_reg);
                mul_b      = uext(34'(hz_reg));
                state_next = ST_CHK;
            end
            ST_CHK: begin
                nl_next = nl_tmp[47:30];
                // sample counts only with positive vdoth, hz and ndotl
                if (!vdoth_reg[32] && (vdoth_reg != '0) && (hz_reg != '0)
                        && !ndotl_c[49] && (ndotl_c != '0)) begin
                    mul_a      = uext(34'(r_reg));
                    mul_b      = uext(34'(r_reg));
                    state_next = ST_KSET;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_KSET: begin
                k_next     = prod[30:1];
                state_next = ST_D1M;
            end
            ST_D1M: begin
                mul_a      = uext(34'(v_reg));
                mul_b      = uext(34'(one_minus_k));
                state_next = ST_D1GO;
            end
            ST_D1GO: begin
                div_start  = 1'b1;
                div_num    = {3'b0, v_reg, 45'b0};
                div_den    = 46'(dsum);
                state_next = ST_DIV1;
            end
            ST_DIV1: begin
                if (div_st.done) begin
                    g1v_next   = div_q;
                    state_next = ST_D2M;
                end
            end
            ST_D2M: begin
                mul_a      = uext(34'(nl_reg));
                mul_b      = uext(34'(one_minus_k));
                state_next = ST_D2GO;
            end
            ST_D2GO: begin
                // vanishing light term with zero k counts as one
                if (dsum == '0) begin
                    g1n_next   = 33'h0_4000_0000;
                    state_next = ST_GM;
                end else begin
                    div_start  = 1'b1;
                    div_num    = {1'b0, nl_reg, 45'b0};
                    div_den    = 46'(dsum);
                    state_next = ST_DIV2;
                end
            end
            ST_DIV2: begin
                if (div_st.done) begin
                    g1n_next   = div_q;
                    state_next = ST_GM;
                end
            end
            ST_GM: begin
                mul_a      = uext(34'(g1v_reg));
                mul_b      = uext(34'(g1n_reg));
                state_next = ST_GSET;
            end
            ST_GSET: begin
                g_next     = prod[63:30];
                state_next = ST_HVM;
            end
            ST_HVM: begin
                mul_a      = uext(34'(hz_reg));
                mul_b      = uext(34'(v_reg));
                state_next = ST_WM;
            end
            ST_WM: begin
                den_next   = {prod[30:0], 15'b0};
                mul_a      = uext(g_reg);
                mul_b      = MUL_W'(vdoth_reg);
                state_next = ST_WGO;
            end
            ST_WGO: begin
                div_start  = 1'b1;
                div_num    = prod[63:0];
                div_den    = den_reg;
                state_next = ST_DIV3;
            end
            ST_DIV3: begin
                if (div_st.done) begin
                    if (div_st.ovf || (div_q > 33'(W_MAX))) begin
                        w_next = W_MAX;
                    end else begin
                        w_next = div_q[19:0];
                    end
                    // fresnel base, vdoth clamped to one
                    if (vd15 > 19'(Q15_ONE)) begin
                        fc_next = '0;
                    end else begin
                        fc_next = Q15_ONE - vd15[15:0];
                    end
                    state_next = ST_F4M;
                end
            end
            ST_F4M: begin
                mul_a      = uext(34'(fc_reg));
                mul_b      = uext(34'(fc_reg));
                state_next = ST_F5M;
            end
            ST_F5M: begin
                // square of fc squared
                mul_a      = uext(34'(rq[15:0]));
                mul_b      = uext(34'(rq[15:0]));
                state_next = ST_F5;
            end
            ST_F5: begin
                mul_a      = uext(34'(rq[15:0]));
                mul_b      = uext(34'(fc_reg));
                state_next = ST_SC;
            end
            ST_SC: begin
                f5_next    = rq[15:0];
                mul_a      = uext(34'(Q15_ONE - rq[15:0]));
                mul_b      = uext(34'(w_reg));
                state_next = ST_BI;
            end
            ST_BI: begin
                scale_sum_next = (add_s > {1'b0, SUM_MAX}) ? SUM_MAX : add_s[29:0];
                mul_a          = uext(34'(f5_reg));
                mul_b          = uext(34'(w_reg));
                state_next     = ST_BADD;
            end
            ST_BADD: begin
                // bias product lands here
                bias_sum_next = (add_b > {1'b0, SUM_MAX}) ? SUM_MAX : add_b[29:0];
                state_next    = ST_DONE;
            end
            ST_DONE: begin
                if (last_reg) begin
                    if (out_free) begin
                        m_tdata_next   = {avg_sat(avg_b), avg_sat(avg_s)};
                        m_tvalid_next  = 1'b1;
                        scale_sum_next = '0;
                        bias_sum_next  = '0;
                        state_next     = ST_IDLE;
                    end
                end else begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // sequencer handles one word at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word taken while busy");

    // sums are cleared together with the emit
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> (scale_sum_reg == '0) && (bias_sum_reg == '0))
        else $error("sums not cleared on emit");

    // root unit finishes only while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        sq_done |-> (state_reg == ST_ROOT))
        else $error("unexpected root completion");

    // divider finishes only in a divide wait state
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_st.done |-> (state_reg == ST_DIV1 || state_reg == ST_DIV2
                         || state_reg == ST_DIV3))
        else $error("unexpected divide completion");

endmodule

### tb/split_sum_brdf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// split_sum_brdf_checker
// watches both channels of the brdf integrator, predicts the scale and bias
// averages of each run and compares every output word with the oldest one
// ----------------------------------------------------------------------------
module split_sum_brdf_checker #(
    parameter int unsigned LOG2_SAMPLES = 10
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    input  logic                                  s_tready,
    input  logic [ssbi_pkg::IN_TDATA_W-1:0]       s_tdata,
    input  logic                                  s_tlast,
    input  logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic [ssbi_pkg::OUT_TDATA_W-1:0]      m_tdata,
    output int                                    fail_count,
    output int                                    pending_count,
    output int                                    run_count
);

    typedef struct packed {
        logic [15:0] bias_b;
        logic [15:0] scale_a;
    } avg_pair_t;

    logic [29:0] scale_acc;
    logic [29:0] bias_acc;
    avg_pair_t   avg_q[$];

    function automatic logic [63:0] isqrt(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bit_v;
        res   = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > x) bit_v = bit_v >> 2;
        while (bit_v != 0) begin
            if (x >= res + bit_v) begin
                x   = x - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] masking(input logic [63:0] x, input logic [63:0] k30);
        logic [63:0] d;
        d = ((x * ((64'd1 << 30) - k30)) >> 15) + k30;
        if (d == 0) return 64'd1 << 30;
        return (x << 45) / d;
    endfunction

    function automatic logic [31:0] qmul(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = 64'(a) * 64'(b) + 64'd16384;
        return 32'(p >> 15);
    endfunction

    function automatic logic [29:0] sat_acc(input logic [29:0] s, input logic [31:0] t);
        logic [32:0] r;
        r = 33'(s) + 33'(t);
        return (r > 33'(ssbi_pkg::SUM_MAX)) ? ssbi_pkg::SUM_MAX : r[29:0];
    endfunction

    function automatic logic [15:0] avg_of(input logic [29:0] s);
        logic [31:0] r;
        r = (32'(s) + (32'd1 << (LOG2_SAMPLES - 1))) >> LOG2_SAMPLES;
        return (r > 32'd65535) ? 16'hFFFF : r[15:0];
    endfunction

    // accumulate one sample into the running sums
    task automatic accumulate_sample(input logic [71:0] d);
        logic [63:0] v, r, hz, vx, k30, nl, g, w, vd15;
        logic signed [63:0] hx, vdoth, ndotl;
        logic [31:0] fc, f2, f4, f5;
        v  = d[15:0];
        r  = d[31:16];
        hx = {{47{d[48]}}, d[48:32]};
        hz = d[64:49];
        if (v == 0) v = 1;
        if (v > 32768) v = 32768;
        if (r > 32768) r = 32768;
        if (hz > 32768) hz = 32768;
        if (hx > 32768) hx = 32768;
        if (hx < -32768) hx = -32768;
        vx    = isqrt((64'd1 << 30) - v * v);
        vdoth = $signed(vx) * hx + $signed(v) * $signed(hz);
        ndotl = 2 * vdoth * $signed(hz) - $signed(v << 30);
        if (vdoth > 0 && hz > 0 && ndotl > 0) begin
            k30  = (r * r) >> 1;
            nl   = (64'(ndotl) + (64'd1 << 29)) >> 30;
            g    = (masking(v, k30) * masking(nl, k30)) >> 30;
            w    = (g * 64'(vdoth)) / ((hz * v) << 15);
            vd15 = (64'(vdoth) + 64'd16384) >> 15;
            if (w > 64'(ssbi_pkg::W_MAX)) w = 64'(ssbi_pkg::W_MAX);
            if (vd15 > 32768) vd15 = 32768;
            fc = 32'(32768 - vd15);
            f2 = qmul(fc, fc);
            f4 = qmul(f2, f2);
            f5 = qmul(f4, fc);
            scale_acc = sat_acc(scale_acc, qmul(32768 - f5, 32'(w)));
            bias_acc  = sat_acc(bias_acc, qmul(f5, 32'(w)));
        end
    endtask

    always @(posedge aclk) begin
        avg_pair_t got, want;
        if (!aresetn) begin
            scale_acc     = '0;
            bias_acc      = '0;
            fail_count    = 0;
            pending_count = 0;
            run_count     = 0;
            avg_q.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                accumulate_sample(s_tdata);
                if (s_tlast) begin
                    want.scale_a = avg_of(scale_acc);
                    want.bias_b  = avg_of(bias_acc);
                    avg_q.push_back(want);
                    scale_acc = '0;
                    bias_acc  = '0;
                end
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (avg_q.size() == 0) begin
                    $error("unexpected output word %h", m_tdata);
                    fail_count = fail_count + 1;
                end else begin
                    want = avg_q.pop_front();
                    run_count = run_count + 1;
                    if (got.scale_a !== want.scale_a) begin
                        $error("scale_a expected %0d actual %0d", want.scale_a, got.scale_a);
                        fail_count = fail_count + 1;
                    end
                    if (got.bias_b !== want.bias_b) begin
                        $error("bias_b expected %0d actual %0d", want.bias_b, got.bias_b);
                        fail_count = fail_count + 1;
                    end
                end
            end
            pending_count = avg_q.size();
        end
    end

endmodule

### tb/split_sum_brdf_integrator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// split_sum_brdf_integrator_tb
// drives runs of half-vector samples with random gaps and output stalls;
// the checker predicts every run's averages and counts mismatches
// ----------------------------------------------------------------------------
module split_sum_brdf_integrator_tb;

    localparam int unsigned LOG2_SAMPLES = 10;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    int          fail_count, pending_count, run_count;
    int          sent_count;
    bit          stim_done = 1'b0;

    always #10 aclk = ~aclk;

    split_sum_brdf_integrator #(.LOG2_SAMPLES(LOG2_SAMPLES)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    split_sum_brdf_checker #(.LOG2_SAMPLES(LOG2_SAMPLES)) i_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending_count(pending_count), .run_count(run_count)
    );

    // mostly short gaps, now and then a long one, sometimes none
    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 40) return 0;
        if (p < 92) return $urandom_range(4, 1);
        return $urandom_range(400, 50);
    endfunction

    // output side stalls at random throughout the run, now and then for long
    initial begin
        int n;
        forever begin
            @(posedge aclk);
            n = gap_len();
            if (n > 20) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= (n == 0) || ($urandom_range(3) == 0);
        end
    end

    // send one sample word and wait until the block takes it
    task automatic send_word(input logic [15:0] v, input logic [15:0] r,
                             input logic [16:0] hx, input logic [15:0] hz,
                             input logic last_s);
        int n;
        n = gap_len();
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, hz, hx, r, v};
        s_tlast  <= last_s;
        do @(posedge aclk); while (!s_tready);
        sent_count++;
    endtask

    // random half vector, sometimes out of range or at extremes
    task automatic random_sample(output logic [16:0] hx, output logic [15:0] hz);
        int p;
        p = $urandom_range(9);
        if (p == 0) begin
            hx = 17'($urandom);
            hz = 16'($urandom);
        end else begin
            hx = 17'($signed($urandom_range(65536)) - 32768);
            hz = 16'($urandom_range(32768, (p < 3) ? 0 : 16384));
        end
    endtask

    initial begin
        logic [15:0] v, r, hz;
        logic [16:0] hx;
        int run_len;
        sent_count = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, zero view cosine, out of range fields, empty geometry
        send_word(16'd0, 16'd32768, 17'd0, 16'd32768, 1'b0);
        send_word(16'd1, 16'd1, 17'h10000, 16'd1, 1'b0);
        send_word(16'd32768, 16'd0, 17'd0, 16'd32768, 1'b0);
        send_word(16'hFFFF, 16'hFFFF, 17'h0FFFF, 16'hFFFF, 1'b1);
        send_word(16'd23170, 16'd0, 17'd23170, 16'd23170, 1'b1);
        send_word(16'd100, 16'd0, 17'h1FFFF, 16'd0, 1'b1);
        send_word(16'd16384, 16'd32768, 17'd28378, 16'd16384, 1'b0);
        send_word(16'd32768, 16'd1, 17'h18000, 16'd32768, 1'b1);
        for (int i = 0; i < 12; i++)
            send_word(16'd1, 16'd0, 17'd0, 16'd32768, i == 11);
        send_word(16'd5, 16'd40000, 17'h12345, 16'd300, 1'b1);

        // random runs, mostly short with a few full length ones
        while (sent_count < 1500) begin
            v = ($urandom_range(15) == 0) ? 16'($urandom) : 16'($urandom_range(32768, 1));
            r = ($urandom_range(15) == 0) ? 16'($urandom) : 16'($urandom_range(32768, 1));
            run_len = ($urandom_range(40) == 0) ? (1 << LOG2_SAMPLES) : $urandom_range(24, 1);
            if (run_len > 1500 - sent_count) run_len = 1500 - sent_count;
            for (int i = 0; i < run_len; i++) begin
                random_sample(hx, hz);
                send_word(v, r, hx, hz, i == run_len - 1);
            end
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        while (pending_count != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        $display("sent %0d samples, checked %0d run averages", sent_count, run_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // 1500 samples plus long gaps and long output stalls
    initial begin
        #150ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
